>>> hdl/bbrp_pkg.sv
// Shared types and constants of the box blur row pass unit.
// No dependencies; referenced by every module of the block.
package bbrp_pkg;

    localparam int MAX_BOX_DEF     = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 4 * CH_W;
    localparam int POS_W      = 16;
    localparam int SIZE_W     = 6;
    localparam int OFF_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int DIST_W     = POS_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_OFFSET = CFG_IDX_W'(1);

    localparam logic [POS_W-1:0] POS_FULL = '1;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
        logic            row_end;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
        logic            row_last;
        logic            run_last;
    } t_pix_out;

    // effective window, already clamped
    typedef struct packed {
        logic [SIZE_W-1:0] box;
        logic [OFF_W-1:0]  off;
    } t_cfg;

    // one classified source pixel on its way to the back end
    typedef struct packed {
        logic [PIX_W-1:0] pixel;    // red in the low byte
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] x_start;
        logic [POS_W-1:0] hi;
        logic             emit;     // at least one output completes
        logic             row_end;  // row closes with this pixel
        logic             pass;     // pass-through mode
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

>>> hdl/box_blur_row_pass_unit.sv
// Box blur row pass unit, top level: front end, job queue and back end.
// Uses bbrp_pkg, bbrp_front, bbrp_queue and bbrp_back.
//
// Usage: source pixels (RGBA plus a row-end flag) enter on the push/full
// queue side; averaged pixels leave on the empty/pop side, oldest first,
// each with row_last and run_last marks. Configuration registers (index 0
// box size, index 1 box offset) are written with i_cfg_we, by the user only
// while the block is idle (unenforced); any such write also restarts the row.
// Timing: with box size 0 a pixel passes through and the block takes one
// pixel per cycle while the receiver keeps up; the pixel goes through the
// job queue into the result register. Otherwise the back end takes a pixel
// and, for each output it completes, reads the history memory once per
// window pixel, accumulates the reads, runs eight divider steps on all four
// channels at once and loads the result register when it is free. A pixel
// that completes no output is only stored in the history memory. The front
// keeps taking pixels into a four-entry queue while the back end works.
// Reset (synchronous, active low) clears registers, positions and queues;
// the history memory needs no clearing. A receiver that holds off pop
// stalls the back end, then the queue fills and full rises.
module box_blur_row_pass_unit #(
    parameter int MAX_BOX     = bbrp_pkg::MAX_BOX_DEF,
    parameter int QUEUE_DEPTH = bbrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bbrp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  bbrp_pkg::t_pix_in               i_pix,
    output logic                            empty,
    input  logic                            pop,
    output bbrp_pkg::t_pix_out              o_pix
);
    import bbrp_pkg::*;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    t_job             front_job;
    t_job             back_job;
    t_cfg             cfg;
    logic [JOB_W-1:0] q_wdata;
    logic [JOB_W-1:0] q_rdata;

    assign full     = q_full;
    assign q_wdata  = front_job;
    assign back_job = q_rdata;

    bbrp_front #(
        .MAX_BOX (MAX_BOX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_job      (front_job),
        .o_cfg      (cfg)
    );

    bbrp_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    bbrp_back #(
        .MAX_BOX (MAX_BOX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_job     (back_job),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_pix     (o_pix)
    );

endmodule

>>> hdl/bbrp_front.sv
// Front end of the box blur row pass unit: configuration registers, row
// bookkeeping and classification of each source pixel. Uses bbrp_pkg.
module bbrp_front #(
    parameter int MAX_BOX = bbrp_pkg::MAX_BOX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bbrp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  bbrp_pkg::t_pix_in              i_pix,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output bbrp_pkg::t_job                 o_job,
    output bbrp_pkg::t_cfg                 o_cfg
);
    import bbrp_pkg::*;

    logic [SIZE_W-1:0] r_box_size;
    logic [OFF_W-1:0]  r_box_off;
    logic [POS_W-1:0]  r_in_pos;
    logic [POS_W-1:0]  r_out_pos;
    logic [POS_W-1:0]  n_in_pos;
    logic [POS_W-1:0]  n_out_pos;

    logic [SIZE_W-1:0]       eff_box;
    logic [OFF_W-1:0]        eff_off;
    logic [SIZE_W-1:0]       lag;
    logic                    pass;
    logic                    end_eff;
    logic                    emit;
    logic                    cfg_hit;
    logic signed [DIST_W-1:0] hi_s;

    always_comb begin
        eff_box = (32'(r_box_size) > MAX_BOX) ? SIZE_W'(MAX_BOX) : r_box_size;
        eff_off = ({1'b0, r_box_off} >= eff_box) ? OFF_W'(eff_box - SIZE_W'(1)) : r_box_off;
        pass    = (r_box_size == '0);
        end_eff = i_pix.row_end || (r_in_pos == POS_FULL);
        // outputs lag the input by the part of the window right of the output
        lag     = eff_box - SIZE_W'(1) - SIZE_W'(eff_off);
        hi_s    = end_eff ? $signed({2'b00, r_in_pos})
                          : $signed({2'b00, r_in_pos}) - $signed(DIST_W'(lag));
        emit    = hi_s >= $signed({2'b00, r_out_pos});
        n_in_pos  = end_eff ? '0 : r_in_pos + POS_W'(1);
        n_out_pos = end_eff ? '0 : (emit ? hi_s[POS_W-1:0] + POS_W'(1) : r_out_pos);
        cfg_hit   = i_cfg_we && (i_cfg_idx == REG_BOX_SIZE || i_cfg_idx == REG_BOX_OFFSET);
    end

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_job.pixel   = {i_pix.alpha_in, i_pix.blue_in, i_pix.green_in, i_pix.red_in};
        o_job.pos     = r_in_pos;
        o_job.x_start = r_out_pos;
        o_job.hi      = hi_s[POS_W-1:0];
        o_job.emit    = emit;
        o_job.row_end = end_eff;
        o_job.pass    = pass;
        o_cfg.box     = eff_box;
        o_cfg.off     = eff_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_size <= '0;
            r_box_off  <= '0;
            r_in_pos   <= '0;
            r_out_pos  <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_idx == REG_BOX_SIZE) begin
                r_box_size <= i_cfg_data[SIZE_W-1:0];
            end else begin
                r_box_off <= i_cfg_data[OFF_W-1:0];
            end
            // restart the row
            r_in_pos  <= '0;
            r_out_pos <= '0;
        end else if (o_q_push && !pass) begin
            r_in_pos  <= n_in_pos;
            r_out_pos <= n_out_pos;
        end
    end

endmodule

>>> hdl/bbrp_queue.sv
// Short first-in first-out queue between front and back end.
// Generic width; uses bbrp_pkg only for its parameter defaults.
module bbrp_queue #(
    parameter int DATA_W = bbrp_pkg::JOB_W,
    parameter int DEPTH  = bbrp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("queue full and empty at once");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CW'(DEPTH)) && (r_cnt != '0 || r_wr == r_rd))
        else $error("queue count out of range or pointers disagree");
`endif

endmodule

>>> hdl/bbrp_back.sv
// Back end of the box blur row pass unit: pixel history memory, window
// accumulation, per-channel divider and the result register. Uses bbrp_pkg.
module bbrp_back #(
    parameter int MAX_BOX = bbrp_pkg::MAX_BOX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbrp_pkg::t_cfg     i_cfg,
    input  logic               i_q_empty,
    input  bbrp_pkg::t_job     i_job,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output bbrp_pkg::t_pix_out o_pix
);
    import bbrp_pkg::*;

    localparam int AW = (MAX_BOX > 1) ? $clog2(MAX_BOX) : 1;
    localparam int CW = $clog2(MAX_BOX + 1);
    localparam int SW = $clog2(MAX_BOX * 255 + 1);
    localparam int RW = CW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic [PIX_W-1:0] r_hist [MAX_BOX];
    logic [PIX_W-1:0] r_first;
    logic [PIX_W-1:0] r_rd_data;
    logic             r_rd_first;
    logic             r_acc_v;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_hi;
    logic [POS_W-1:0] r_x;
    logic             r_end;
    logic [AW-1:0]    r_slot_p;
    logic [AW-1:0]    r_slot_next;
    logic [CW-1:0]    r_cnt;
    logic signed [DIST_W-1:0] r_d;
    logic signed [DIST_W-1:0] r_dbase;

    logic [SW-1:0]   r_sum [4];
    logic [RW-1:0]   r_rem [4];
    logic [CH_W-1:0] r_quo [4];
    logic [2:0]      r_div_cnt;

    t_pix_out r_out;
    logic     r_out_v;

    logic                     out_free;
    logic                     take;
    logic                     pass_load;
    logic                     emit_load;
    logic                     issue;
    logic                     use_first;
    logic                     sum_done;
    logic                     last_x;
    logic [CW-1:0]            b_cnt;
    logic [RW-1:0]            b_rem;
    logic [AW-1:0]            d_eff;
    logic [AW-1:0]            rd_slot;
    logic [AW-1:0]            wr_slot;
    logic [AW:0]              wrap_slot;
    logic signed [DIST_W-1:0] dbase0;
    logic [PIX_W-1:0]         acc_px;
    logic [RW-1:0]            step_t [4];
    logic                     step_ge [4];

    assign out_free  = !r_out_v || i_pop;
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty && (!i_job.pass || out_free);
    assign take      = o_q_pop;
    assign pass_load = take && i_job.pass;
    assign emit_load = (r_state == S_EMIT) && out_free;
    assign b_cnt     = CW'(i_cfg.box);
    assign b_rem     = RW'(i_cfg.box);
    assign issue     = (r_state == S_SUM) && (r_cnt != b_cnt);
    assign sum_done  = (r_state == S_SUM) && !issue && !r_acc_v;
    assign last_x    = (r_x == r_hi);
    assign o_empty   = !r_out_v;
    assign o_pix     = r_out;

    always_comb begin
        // distance back from the newest pixel; past the row start reads pixel 0
        use_first = r_d >= $signed({2'b00, r_pos});
        d_eff     = (r_d[DIST_W-1] || r_d == '0) ? '0 : r_d[AW-1:0];
        wrap_slot = (AW + 1)'(r_slot_p) + (AW + 1)'(MAX_BOX) - (AW + 1)'(d_eff);
        rd_slot   = (r_slot_p >= d_eff) ? r_slot_p - d_eff : wrap_slot[AW-1:0];
        wr_slot   = (i_job.pos == '0) ? '0 : r_slot_next;
        dbase0    = $signed({2'b00, i_job.pos}) - $signed({2'b00, i_job.x_start})
                    + $signed(DIST_W'(i_cfg.off));
        acc_px    = r_rd_first ? r_first : r_rd_data;
        for (int c = 0; c < 4; c++) begin
            step_t[c]  = {r_rem[c][RW-2:0], r_quo[c][CH_W-1]};
            step_ge[c] = step_t[c] >= b_rem;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && !i_job.pass && i_job.emit) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (sum_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == 3'd7) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state = last_x ? S_IDLE : S_SUM;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_acc_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc_v <= issue;
            if (pass_load || emit_load) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (take && !i_job.pass) begin
            r_hist[wr_slot] <= i_job.pixel;
        end
        if (issue) begin
            r_rd_data <= r_hist[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_job.pass) begin
            if (i_job.pos == '0) begin
                r_first <= i_job.pixel;
            end
            r_pos       <= i_job.pos;
            r_hi        <= i_job.hi;
            r_end       <= i_job.row_end;
            r_x         <= i_job.x_start;
            r_dbase     <= dbase0;
            r_d         <= dbase0;
            r_cnt       <= '0;
            r_slot_p    <= wr_slot;
            r_slot_next <= (wr_slot == AW'(MAX_BOX - 1)) ? '0 : wr_slot + AW'(1);
            for (int c = 0; c < 4; c++) begin
                r_sum[c] <= '0;
            end
        end

        if (issue) begin
            r_cnt      <= r_cnt + CW'(1);
            r_d        <= r_d - DIST_W'(1);
            r_rd_first <= use_first;
        end

        if (r_state == S_SUM && r_acc_v) begin
            for (int c = 0; c < 4; c++) begin
                r_sum[c] <= r_sum[c] + SW'(acc_px[CH_W*c +: CH_W]);
            end
        end

        // the quotient fits in a channel, so only its low eight bits are developed
        if (sum_done) begin
            r_div_cnt <= '0;
            for (int c = 0; c < 4; c++) begin
                r_rem[c] <= RW'(r_sum[c] >> CH_W);
                r_quo[c] <= r_sum[c][CH_W-1:0];
            end
        end

        if (r_state == S_DIV) begin
            r_div_cnt <= r_div_cnt + 3'd1;
            for (int c = 0; c < 4; c++) begin
                r_rem[c] <= step_ge[c] ? step_t[c] - b_rem : step_t[c];
                r_quo[c] <= {r_quo[c][CH_W-2:0], step_ge[c]};
            end
        end

        if (emit_load && !last_x) begin
            // advance to the next output of this run
            r_x     <= r_x + POS_W'(1);
            r_dbase <= r_dbase - DIST_W'(1);
            r_d     <= r_dbase - DIST_W'(1);
            r_cnt   <= '0;
            for (int c = 0; c < 4; c++) begin
                r_sum[c] <= '0;
            end
        end

        if (pass_load) begin
            r_out.red_out   <= i_job.pixel[0*CH_W +: CH_W];
            r_out.green_out <= i_job.pixel[1*CH_W +: CH_W];
            r_out.blue_out  <= i_job.pixel[2*CH_W +: CH_W];
            r_out.alpha_out <= i_job.pixel[3*CH_W +: CH_W];
            r_out.row_last  <= i_job.row_end;
            r_out.run_last  <= 1'b1;
        end else if (emit_load) begin
            r_out.red_out   <= r_quo[0];
            r_out.green_out <= r_quo[1];
            r_out.blue_out  <= r_quo[2];
            r_out.alpha_out <= r_quo[3];
            r_out.row_last  <= r_end && last_x;
            r_out.run_last  <= last_x;
        end
    end

`ifndef SYNTHESIS
    a_rem_below_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem[0] < b_rem) && (r_rem[3] < b_rem))
        else $error("divider remainder not below box size");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_cnt <= b_cnt))
        else $error("window read count past box size");
    a_window_in_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !use_first) |-> (7'(d_eff) < 7'(i_cfg.box)))
        else $error("window reaches beyond stored history");
`endif

endmodule

>>> dv/bbrp_checker.sv
// Scoreboard for the box blur row pass unit: mirrors register writes and
// source pixels, predicts the blurred pixels and checks them in order.
// Depends on bbrp_pkg only.
module bbrp_checker #(
    parameter int MAX_BOX = bbrp_pkg::MAX_BOX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bbrp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbrp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    input  logic                            full,
    input  bbrp_pkg::t_pix_in               i_pix,
    input  logic                            empty,
    input  logic                            pop,
    input  bbrp_pkg::t_pix_out              o_pix,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bbrp_pkg::*;

    localparam int MAX_REPORTS = 40;

    logic [SIZE_W-1:0] box_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [PIX_W-1:0]  row_hist [MAX_BOX];
    logic [PIX_W-1:0]  row_first;
    int                src_pos;
    int                dst_pos;
    t_pix_out          blurred_q [$];
    int                errors = 0;
    int                results_seen = 0;

    assign o_fail_count = errors;

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] MISMATCH on result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Clamp to edge: left of the row reads the first pixel, right of it the newest.
    function automatic logic [PIX_W-1:0] tap(int q, int last_pos);
        if (q <= 0)
            return row_first;
        if (q > last_pos)
            q = last_pos;
        return row_hist[q % MAX_BOX];
    endfunction

    function automatic t_pix_out box_average(int x, int last_pos, int b, int o);
        int               sum [4];
        logic [PIX_W-1:0] px;
        t_pix_out         res;
        for (int c = 0; c < 4; c++)
            sum[c] = 0;
        for (int i = 0; i < b; i++) begin
            px = tap(x - o + i, last_pos);
            for (int c = 0; c < 4; c++)
                sum[c] += px[CH_W*c +: CH_W];
        end
        res           = '0;
        res.red_out   = CH_W'(sum[0] / b);
        res.green_out = CH_W'(sum[1] / b);
        res.blue_out  = CH_W'(sum[2] / b);
        res.alpha_out = CH_W'(sum[3] / b);
        return res;
    endfunction

    task automatic blur_source_pixel(t_pix_in px);
        logic [PIX_W-1:0] word;
        logic             row_done;
        int               b;
        int               o;
        int               hi;
        t_pix_out         res;
        if (box_reg == '0) begin
            res           = '0;
            res.red_out   = px.red_in;
            res.green_out = px.green_in;
            res.blue_out  = px.blue_in;
            res.alpha_out = px.alpha_in;
            res.row_last  = px.row_end;
            res.run_last  = 1'b1;
            blurred_q.push_back(res);
            return;
        end
        b = box_reg;
        if (b > MAX_BOX)
            b = MAX_BOX;
        o = off_reg;
        if (o >= b)
            o = b - 1;
        word = {px.alpha_in, px.blue_in, px.green_in, px.red_in};
        row_hist[src_pos % MAX_BOX] = word;
        if (src_pos == 0)
            row_first = word;
        // a row that reaches the position limit closes on its own
        row_done = px.row_end || (src_pos == int'(POS_FULL));
        hi = row_done ? src_pos : src_pos - (b - 1 - o);
        for (int x = dst_pos; x <= hi; x++) begin
            res          = box_average(x, src_pos, b, o);
            res.row_last = row_done && (x == hi);
            res.run_last = (x == hi);
            blurred_q.push_back(res);
        end
        if (dst_pos <= hi)
            dst_pos = (hi + 1) & 16'hFFFF;
        if (row_done) begin
            src_pos = 0;
            dst_pos = 0;
        end else begin
            src_pos = (src_pos + 1) & 16'hFFFF;
        end
    endtask

    task automatic check_result(t_pix_out got);
        t_pix_out want;
        results_seen++;
        if (blurred_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = blurred_q.pop_front();
        check_field("red_out",   got.red_out,   want.red_out);
        check_field("green_out", got.green_out, want.green_out);
        check_field("blue_out",  got.blue_out,  want.blue_out);
        check_field("alpha_out", got.alpha_out, want.alpha_out);
        check_field("row_last",  got.row_last,  want.row_last);
        check_field("run_last",  got.run_last,  want.run_last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_reg = '0;
            off_reg = '0;
            src_pos = 0;
            dst_pos = 0;
            blurred_q.delete();
        end else begin
            if (pop && !empty)
                check_result(o_pix);
            // a write to a mapped register restarts the row; others are dropped
            if (i_cfg_we && i_cfg_idx == REG_BOX_SIZE) begin
                box_reg = i_cfg_data;
                src_pos = 0;
                dst_pos = 0;
            end else if (i_cfg_we && i_cfg_idx == REG_BOX_OFFSET) begin
                off_reg = i_cfg_data[OFF_W-1:0];
                src_pos = 0;
                dst_pos = 0;
            end
            if (push && !full)
                blur_source_pixel(i_pix);
        end
        o_pending <= blurred_q.size();
    end

endmodule

>>> dv/box_blur_row_pass_unit_tb.sv
// Testbench top for the box blur row pass unit: clock, reset, register
// writes, bursty pixel stimulus and a stalling receiver.
// Depends on bbrp_pkg, box_blur_row_pass_unit and bbrp_checker.
module box_blur_row_pass_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bbrp_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 230;
    localparam int STEADY_ROW    = 20;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  pop        = 1'b0;
    t_pix_in               i_pix      = '0;
    logic                  full;
    logic                  empty;
    t_pix_out              o_pix;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int pixels_sent    = 0;
    int results_popped = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    bit bursty         = 1'b1;
    bit rx_quiet       = 1'b0;
    bit hold_req       = 1'b0;
    int holds_done     = 0;

    box_blur_row_pass_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_pix      (i_pix),
        .empty      (empty),
        .pop        (pop),
        .o_pix      (o_pix)
    );

    bbrp_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_pix        (i_pix),
        .empty        (empty),
        .pop          (pop),
        .o_pix        (o_pix),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_pix_in pixel(int r, int g, int b, int a, bit row_end);
        t_pix_in px;
        px.red_in   = CH_W'(r);
        px.green_in = CH_W'(g);
        px.blue_in  = CH_W'(b);
        px.alpha_in = CH_W'(a);
        px.row_end  = row_end;
        return px;
    endfunction

    function automatic t_pix_in rand_pix(bit row_end);
        t_pix_in px;
        {px.red_in, px.green_in, px.blue_in, px.alpha_in} = $urandom;
        px.row_end = row_end;
        return px;
    endfunction

    // Offer one request; bursts of random length, with random gaps between them when bursty is set.
    task automatic feed(t_pix_in px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push  <= 1'b1;
        i_pix <= px;
        do @(posedge i_clk); while (full);
        pixels_sent++;
    endtask

    // Drop push, wait for every expected result, then let the back end go quiet.
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] box, logic [CFG_DATA_W-1:0] off);
        settle();
        write_reg(REG_BOX_SIZE, box);
        write_reg(REG_BOX_OFFSET, off);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_box_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 75)
            return CFG_DATA_W'($urandom_range(1, 6));
        if (r < 92)
            return CFG_DATA_W'($urandom_range(7, 32));
        return CFG_DATA_W'($urandom_range(33, 63));
    endfunction

    task automatic random_phase();
        int   rows;
        int   len;
        int   kind;
        logic row_flag;
        configure(pick_box_size(), CFG_DATA_W'($urandom_range(0, 63)));
        bursty = ($urandom_range(0, 3) != 0);
        rows   = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
            kind = $urandom_range(0, 9);
            len  = (kind == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++) begin
                // noise rows end anywhere; broken rows are never closed
                if (kind == 1)
                    row_flag = ($urandom_range(0, 3) == 0);
                else
                    row_flag = (i == len - 1) && (kind != 2);
                feed(rand_pix(row_flag));
            end
        end
    endtask

    // Receiver: switches between quiet, light and heavy stall patterns.
    initial begin : rx
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode       = 0;
        mode_left  = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                results_popped++;
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (rx_quiet || !i_rst_n) begin
                pop <= i_rst_n;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (mode == 0 || $urandom_range(0, 99) >= ((mode == 1) ? 15 : 50)) begin
                pop <= 1'b1;
            end else begin
                stall_left = $urandom_range(0, (mode == 1) ? 3 : 12);
                pop <= 1'b0;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through straight out of reset
        feed(pixel(0, 0, 0, 0, 1'b0));
        feed(pixel(255, 255, 255, 255, 1'b1));
        feed(pixel(8'h5A, 8'hA5, 8'h0F, 8'hF0, 1'b0));

        // single-pixel row, then extremes through a centered window
        configure(CFG_DATA_W'(3), CFG_DATA_W'(1));
        feed(pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
        feed(pixel(255, 255, 255, 255, 1'b0));
        feed(pixel(0, 0, 0, 0, 1'b0));
        feed(pixel(255, 255, 255, 255, 1'b0));
        feed(pixel(0, 0, 0, 0, 1'b0));
        feed(pixel(8'h80, 8'h01, 8'hFE, 8'h7F, 1'b1));

        // widest box and offset
        configure(CFG_DATA_W'(32), CFG_DATA_W'(31));
        feed(pixel(0, 0, 0, 0, 1'b0));
        feed(pixel(255, 255, 255, 255, 1'b0));
        feed(pixel(8'h12, 8'hED, 8'h33, 8'hCC, 1'b1));

        // oversized box clamps to the maximum
        configure(CFG_DATA_W'(63), CFG_DATA_W'(0));
        for (int i = 0; i < 4; i++)
            feed(rand_pix(i == 3));

        // offset beyond the box; mid-row writes to unmapped and mapped registers
        configure(CFG_DATA_W'(4), CFG_DATA_W'(20));
        for (int i = 0; i < 3; i++)
            feed(rand_pix(1'b0));
        settle();
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, CFG_DATA_W'(6'h2A));
        i_cfg_we <= 1'b0;
        feed(rand_pix(1'b0));
        settle();
        write_reg(REG_BOX_SIZE, CFG_DATA_W'(4));
        i_cfg_we <= 1'b0;
        feed(rand_pix(1'b0));
        feed(rand_pix(1'b1));

        // back-to-back row into a receiver that never stalls, then a short row
        configure(CFG_DATA_W'(2), CFG_DATA_W'(0));
        bursty   = 1'b0;
        rx_quiet = 1'b1;
        for (int i = 0; i < STEADY_ROW; i++)
            feed(rand_pix(i == STEADY_ROW - 1));
        for (int i = 0; i < 3; i++)
            feed(rand_pix(i == 2));
        settle();
        rx_quiet = 1'b0;

        // hold off the receiver while a row keeps coming, so full must rise
        configure(CFG_DATA_W'(3), CFG_DATA_W'(1));
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            feed(rand_pix(i == 23));

        while (pixels_sent < ITEM_TARGET)
            random_phase();

        settle();
        $display("Run covered %0d source pixels under %0d register settings",
                 pixels_sent, settings_used);
        $display("%0d blurred pixels drained, %0d receiver hold-off(s), %0d cycles",
                 results_popped, holds_done, cycle_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
